// File: sv/char_lcd_scrolling_terminal_core_assert.svh
// Assertion macros for the character LCD terminal core.
// Needs clk and rst_n in the including scope.
`ifndef CHAR_LCD_SCROLLING_TERMINAL_CORE_ASSERT_SVH
`define CHAR_LCD_SCROLLING_TERMINAL_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CLCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define CLCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/clcd_pkg.sv
// Shared types, constants and the microcode ROM for the character LCD terminal.
// No dependencies.
package clcd_pkg;

  localparam int COLUMNS_DEF = 16;
  localparam int UPC_W       = 4;

  localparam logic [1:0] KIND_NIBBLE = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] LINE0_ADDR = 8'h80;
  localparam logic [7:0] LINE1_ADDR = 8'hC0;

  // Program entry points
  localparam logic [UPC_W-1:0] ENTRY_INIT   = 4'd0;
  localparam logic [UPC_W-1:0] ENTRY_SCROLL = 4'd8;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       from_row;  // data comes from the shadow row
    logic       loop;      // repeat once per column
    logic       done;      // final write of the program
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] upc);
    ucode_t w;
    w = '{kind: KIND_CMD, value: LINE1_ADDR, from_row: 1'b0, loop: 1'b0, done: 1'b1};
    unique case (upc)
      4'd0:    w = '{KIND_NIBBLE, 8'h30, 1'b0, 1'b0, 1'b0};
      4'd1:    w = '{KIND_NIBBLE, 8'h30, 1'b0, 1'b0, 1'b0};
      4'd2:    w = '{KIND_NIBBLE, 8'h30, 1'b0, 1'b0, 1'b0};
      4'd3:    w = '{KIND_NIBBLE, 8'h20, 1'b0, 1'b0, 1'b0};
      4'd4:    w = '{KIND_CMD,    8'h28, 1'b0, 1'b0, 1'b0};
      4'd5:    w = '{KIND_CMD,    8'h0C, 1'b0, 1'b0, 1'b0};
      4'd6:    w = '{KIND_CMD,    8'h01, 1'b0, 1'b0, 1'b0};
      4'd7:    w = '{KIND_CMD,    8'h06, 1'b0, 1'b0, 1'b0};
      4'd8:    w = '{KIND_CMD,    LINE0_ADDR, 1'b0, 1'b0, 1'b0};
      4'd9:    w = '{KIND_DATA,   CH_SPACE,   1'b1, 1'b1, 1'b0};
      4'd10:   w = '{KIND_CMD,    LINE1_ADDR, 1'b0, 1'b0, 1'b0};
      4'd11:   w = '{KIND_DATA,   CH_SPACE,   1'b0, 1'b1, 1'b0};
      4'd12:   w = '{KIND_CMD,    LINE1_ADDR, 1'b0, 1'b0, 1'b1};
      default: w = '{KIND_CMD,    LINE1_ADDR, 1'b0, 1'b0, 1'b1};
    endcase
    return w;
  endfunction

endpackage

// File: sv/clcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module clcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/clcd_seq.sv
// Microcode sequencer: step counter, per-column loop counter and control ROM.
// Depends on clcd_pkg.
module clcd_seq #(
  parameter int COLUMNS = clcd_pkg::COLUMNS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        start,
  input  logic [clcd_pkg::UPC_W-1:0]                  entry,
  input  logic                                        adv,
  output logic                                        busy,
  output clcd_pkg::ucode_t                            cw,
  output logic [(COLUMNS > 1 ? $clog2(COLUMNS) : 1)-1:0] idx,
  output logic [(COLUMNS > 1 ? $clog2(COLUMNS) : 1)-1:0] idx_next
);
  import clcd_pkg::*;

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(COLUMNS - 1);

  logic             busy_r, busy_nxt;
  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= '0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      upc_r  <= upc_nxt;
      idx_r  <= idx_nxt;
    end
  end

  assign cw = ucode_rom(upc_r);

  always_comb begin
    busy_nxt = busy_r;
    upc_nxt  = upc_r;
    idx_nxt  = idx_r;
    if (start) begin
      busy_nxt = 1'b1;
      upc_nxt  = entry;
      idx_nxt  = '0;
    end else if (busy_r && adv) begin
      if (cw.loop && idx_r != LAST_IDX) begin
        idx_nxt = idx_r + 1'b1;
      end else begin
        idx_nxt = '0;
        if (cw.done) begin
          busy_nxt = 1'b0;
          upc_nxt  = '0;
        end else begin
          upc_nxt = upc_r + 1'b1;
        end
      end
    end
  end

  assign busy     = busy_r;
  assign idx      = idx_r;
  assign idx_next = idx_nxt;

endmodule

// File: sv/char_lcd_scrolling_terminal_core.sv
// Character terminal for a two-line HD44780-style display.
// Channels: input beats carry in_action (0 = put character, 1 = initialise)
// and in_character; output beats carry one controller write each
// (out_write_kind, out_bus_value, out_last), out_last set on the final write
// of an input beat. Both channels use valid/stall.
// Output: a printable character appears on the output the cycle after it
// is accepted. A newline gives 2*COLUMNS+3 writes, one a cycle while the
// output is not stalled, passing the sequencer state register and then the
// output register; init gives 2*COLUMNS+11 writes likewise. The microcode
// sequencer issues these from its ROM, and in_stall stays high until it is
// done. Characters can be taken back to back; one past the row end is taken
// and gives nothing.
// Reset: rst_n low (synchronous) empties the output register, idles the
// sequencer, zeroes the column and marks the shadow row as all spaces.
// Stall: while out_stall holds a write, the sequencer freezes and in_stall
// stays high; nothing is lost or repeated.
// Depends on clcd_pkg, clcd_seq, clcd_ram and the assertion macro header.
module char_lcd_scrolling_terminal_core #(
  parameter int COLUMNS = clcd_pkg::COLUMNS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_action,
  input  logic [7:0] in_character,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_write_kind,
  output logic [7:0] out_bus_value,
  output logic       out_last
);
  import clcd_pkg::*;

  `include "char_lcd_scrolling_terminal_core_assert.svh"

  localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int COL_W = $clog2(COLUMNS + 1);

  // Output register
  logic       out_valid_r, out_valid_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [7:0] value_r, value_nxt;
  logic       last_r, last_nxt;

  // Column and shadow-row valid bits (an invalid entry reads as a space)
  logic [COL_W-1:0] col_r, col_nxt;
  logic [COLUMNS-1:0] rowv_r, rowv_nxt;

  logic             out_free, in_accept;
  logic             is_init, is_nl, is_put;
  logic             seq_start, seq_busy, fire;
  logic [UPC_W-1:0] seq_entry;
  ucode_t           cw;
  logic [IDX_W-1:0] idx, idx_next, col_idx;
  logic [7:0]       row_rdata, row_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = seq_busy || !out_free;
  assign in_accept = in_valid && !in_stall;

  assign is_init = in_action;
  assign is_nl   = !in_action && (in_character == CH_NEWLINE);
  assign is_put  = !in_action && !is_nl && (col_r < COL_W'(COLUMNS));
  assign col_idx = col_r[IDX_W-1:0];

  assign seq_start = in_accept && (is_init || is_nl);
  assign seq_entry = is_init ? ENTRY_INIT : ENTRY_SCROLL;
  assign fire      = seq_busy && out_free;

  clcd_seq #(
    .COLUMNS(COLUMNS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (seq_start),
    .entry    (seq_entry),
    .adv      (out_free),
    .busy     (seq_busy),
    .cw       (cw),
    .idx      (idx),
    .idx_next (idx_next)
  );

  // Read address follows the loop counter's next value, so the read data
  // always matches the current column index.
  clcd_ram #(
    .WIDTH(8),
    .DEPTH(COLUMNS)
  ) u_row (
    .clk   (clk),
    .we    (in_accept && is_put),
    .waddr (col_idx),
    .wdata (in_character),
    .raddr (idx_next),
    .rdata (row_rdata)
  );

  assign row_byte = rowv_r[idx] ? row_rdata : CH_SPACE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      col_r       <= '0;
      rowv_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      col_r       <= col_nxt;
      rowv_r      <= rowv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    value_r <= value_nxt;
    last_r  <= last_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    col_nxt       = col_r;
    rowv_nxt      = rowv_r;
    priority if (fire) begin
      out_valid_nxt = 1'b1;
      kind_nxt      = cw.kind;
      value_nxt     = cw.from_row ? row_byte : cw.value;
      last_nxt      = cw.done;
      if (cw.done) begin
        // end of scroll: bottom row blank, cursor home
        col_nxt  = '0;
        rowv_nxt = '0;
      end
    end else if (in_accept && is_put) begin
      out_valid_nxt     = 1'b1;
      kind_nxt          = KIND_DATA;
      value_nxt         = in_character;
      last_nxt          = 1'b1;
      col_nxt           = col_r + 1'b1;
      rowv_nxt[col_idx] = 1'b1;
    end else begin
      if (out_free) begin
        out_valid_nxt = 1'b0;
      end
      if (in_accept && is_init) begin
        rowv_nxt = '0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_write_kind = kind_r;
  assign out_bus_value  = value_r;
  assign out_last       = last_r;

  `CLCD_ASSERT_NEXT(a_start_busy, seq_start, seq_busy, "sequencer did not start")
  `CLCD_ASSERT_NEXT(a_done_idle, fire && cw.done, !seq_busy && out_last && col_r == '0,
                    "scroll end did not idle and home the cursor")
  `CLCD_ASSERT_NOW(a_col_bound, 1'b1, col_r <= COL_W'(COLUMNS), "column past row end")

endmodule
